FILE: hdl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SCH_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scheduler assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define SCH_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

FILE: hdl/mlpts_pkg.sv
// Shared types and codes of the multilevel priority task scheduler.
// Depends on nothing; used by the controller, the datapath and the top level.
package mlpts_pkg;

  // Command codes.
  localparam logic [2:0] CMD_BEGIN    = 3'd0;
  localparam logic [2:0] CMD_IO_DONE  = 3'd1;
  localparam logic [2:0] CMD_CREATE   = 3'd2;
  localparam logic [2:0] CMD_DISPATCH = 3'd3;
  localparam logic [2:0] CMD_EXECUTE  = 3'd4;

  // Instruction opcodes that block the running task.
  localparam logic [2:0] OPC_SLEEP  = 3'd4;
  localparam logic [2:0] OPC_IOWAIT = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Configuration register indexes.
  localparam logic REG_QUANTUM_LENGTH = 1'b0;
  localparam logic REG_QUANTUM_FIRST  = 1'b1;

  localparam logic [7:0] QUANTUM_RESET   = 8'd10;
  localparam logic [3:0] QFIRST_RESET    = 4'd5;
  localparam logic [4:0] LIVE_MAX        = 5'd31;

  // Micro-operations issued by the controller to the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DECODE,
    OP_SCAN,
    OP_PUSH_WAKE,
    OP_PUSH_CREATE,
    OP_PUSH_PRE,
    OP_PUSH_QEXP,
    OP_POP_RD,
    OP_POP_WR,
    OP_FIN,
    OP_OUT
  } dp_op_e;

  // Status returned by the datapath to the controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       id_ok;
    logic       create_ok;
    logic       io_wait;
    logic       cur_valid;
    logic       best_found;
    logic       preempt;
    logic       qexp;
    logic       sleep_wake;
    logic       scan_last;
    logic       push_ok;
  } dp_stat_t;

endpackage

FILE: hdl/mlpts_ctrl.sv
// Sequencing state machine of the scheduler.
// Depends on mlpts_pkg; drives the datapath by micro-operation codes.
module mlpts_ctrl import mlpts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output logic     load_o,
  output dp_op_e   op_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PUSH_SCAN,
    S_PUSH_IO,
    S_PUSH_CREATE,
    S_PUSH_PRE,
    S_POP_RD,
    S_POP_WR,
    S_PUSH_QEXP,
    S_FIN,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  dp_op_e op_q, op_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_BEGIN: state_d = S_SCAN;
          CMD_IO_DONE: begin
            state_d = (stat_i.id_ok && stat_i.io_wait) ? S_PUSH_IO : S_FIN;
          end
          CMD_CREATE: begin
            state_d = (stat_i.create_ok && stat_i.cur_valid) ? S_PUSH_CREATE : S_FIN;
          end
          CMD_DISPATCH: begin
            if (stat_i.best_found && !stat_i.cur_valid) state_d = S_POP_RD;
            else if (stat_i.best_found && stat_i.preempt) state_d = S_PUSH_PRE;
            else state_d = S_FIN;
          end
          CMD_EXECUTE: begin
            state_d = (stat_i.cur_valid && stat_i.qexp) ? S_PUSH_QEXP : S_FIN;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_SCAN: begin
        if (stat_i.sleep_wake) state_d = S_PUSH_SCAN;
        else if (stat_i.scan_last) state_d = S_FIN;
      end
      S_PUSH_SCAN: begin
        state_d = stat_i.scan_last ? S_FIN : S_SCAN;
      end
      S_PUSH_IO:     state_d = S_FIN;
      S_PUSH_CREATE: state_d = S_FIN;
      S_PUSH_PRE: begin
        state_d = stat_i.push_ok ? S_POP_RD : S_FIN;
      end
      S_POP_RD:    state_d = S_POP_WR;
      S_POP_WR:    state_d = S_FIN;
      S_PUSH_QEXP: state_d = S_FIN;
      S_FIN:       state_d = S_OUT;
      S_OUT:       state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_d)
      S_DECODE:      op_d = OP_DECODE;
      S_SCAN:        op_d = OP_SCAN;
      S_PUSH_SCAN:   op_d = OP_PUSH_WAKE;
      S_PUSH_IO:     op_d = OP_PUSH_WAKE;
      S_PUSH_CREATE: op_d = OP_PUSH_CREATE;
      S_PUSH_PRE:    op_d = OP_PUSH_PRE;
      S_POP_RD:      op_d = OP_POP_RD;
      S_POP_WR:      op_d = OP_POP_WR;
      S_PUSH_QEXP:   op_d = OP_PUSH_QEXP;
      S_FIN:         op_d = OP_FIN;
      S_OUT:         op_d = OP_OUT;
      default:       op_d = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NONE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      done_q  <= (state_q == S_OUT);
    end
  end

  assign load_o = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign op_o   = op_q;
  assign done_o = done_q;

endmodule

FILE: hdl/mlpts_dp.sv
// Datapath of the scheduler: task tables, level queues in one memory, results.
// Depends on mlpts_pkg and assert_macros.svh; sequenced by mlpts_ctrl.
`include "assert_macros.svh"
module mlpts_dp import mlpts_pkg::*; #(
  parameter int MAX_TASKS   = 16,
  parameter int LEVELS      = 10,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  dp_op_e      op_i,
  output dp_stat_t    stat_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic [2:0]  command_i,
  input  logic [3:0]  task_id_i,
  input  logic [3:0]  task_level_i,
  input  logic [2:0]  instr_op_i,
  input  logic [15:0] instr_arg_i,
  input  logic [7:0]  program_length_i,
  output logic        running_valid_o,
  output logic [3:0]  running_task_o,
  output logic [7:0]  running_pc_o,
  output logic        newly_scheduled_o,
  output logic        finished_valid_o,
  output logic [3:0]  finished_task_o,
  output logic [4:0]  live_tasks_o,
  output logic        all_done_o,
  output logic [1:0]  status_o
);

  localparam int TW    = $clog2(MAX_TASKS);
  localparam int LW    = $clog2(LEVELS);
  localparam int SW    = $clog2(QUEUE_DEPTH);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  typedef logic [TW-1:0] tid_t;
  typedef logic [LW-1:0] lvl_t;
  typedef logic [SW-1:0] slot_t;
  typedef logic [FW-1:0] fill_t;
  typedef logic [AW-1:0] addr_t;

  // Latched command fields.
  logic [2:0]  cmd_q;
  logic [3:0]  id_q;
  logic [3:0]  lvl_q;
  logic [2:0]  iop_q;
  logic [15:0] arg_q;
  logic [7:0]  plen_q;

  // Per-task tables; entries are written before they are read.
  lvl_t        prio_q [MAX_TASKS];
  logic [7:0]  pc_q   [MAX_TASKS];
  logic [15:0] sl_q   [MAX_TASKS];
  logic [MAX_TASKS-1:0] sleeping_q, iow_q;

  // Level queues: circular buffers, one region per level.
  tid_t  qmem [DEPTH];
  fill_t fill_q [LEVELS];
  slot_t head_q [LEVELS];
  tid_t  rd_q;

  tid_t  taddr_q, pid_q, cur_task_q, fint_q;
  lvl_t  lsel_q;
  logic  cur_valid_q, newly_q, finv_q, exec_ok_q;
  logic [7:0] qleft_q, qlen_q;
  logic [3:0] qfl_q;
  logic [4:0] live_q;
  logic [1:0] status_q;

  logic       rv_q, rnew_q, rfinv_q, rdone_q;
  logic [3:0] rtask_q, rfint_q;
  logic [7:0] rpc_q;
  logic [4:0] rlive_q;
  logic [1:0] rstat_q;

  tid_t        t;
  lvl_t        prio_t, best;
  logic [7:0]  pc_t, pc_new, qdec;
  logic [15:0] sl_t;
  logic        id_ok, create_ok, best_found, quant, fin, blocked, qexp, wake;
  logic        push_ok, push_op, push_we;
  fill_t       fill_s;
  slot_t       head_s, head_inc, tail_slot;
  logic [SW:0] tail_sum;
  addr_t       base, waddr, raddr;
  logic [4:0]  live_inc, live_dec;

  assign t      = taddr_q;
  assign prio_t = prio_q[t];
  assign pc_t   = pc_q[t];
  assign sl_t   = sl_q[t];

  assign id_ok     = 7'(id_q) < 7'(MAX_TASKS);
  assign create_ok = id_ok && (5'(lvl_q) < 5'(LEVELS));

  // The best level is the lowest-numbered one holding a task.
  always_comb begin
    best       = '0;
    best_found = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (fill_q[i] != '0) begin
        best       = lvl_t'(i);
        best_found = 1'b1;
      end
    end
  end

  assign quant   = 5'(prio_t) >= 5'(qfl_q);
  assign qdec    = (quant && (qleft_q != 8'd0)) ? qleft_q - 8'd1 : qleft_q;
  assign pc_new  = pc_t + 8'd1;
  assign fin     = pc_new >= plen_q;
  assign blocked = (iop_q == OPC_SLEEP) || (iop_q == OPC_IOWAIT);
  assign qexp    = quant && (qdec == 8'd0) && !fin && !blocked;
  assign wake    = sl_t <= 16'd1;

  assign fill_s    = fill_q[lsel_q];
  assign head_s    = head_q[lsel_q];
  assign push_ok   = fill_s < fill_t'(QUEUE_DEPTH);
  assign tail_sum  = (SW + 1)'(head_s) + (SW + 1)'(fill_s);
  assign tail_slot = (tail_sum >= (SW + 1)'(QUEUE_DEPTH)) ?
                     slot_t'(tail_sum - (SW + 1)'(QUEUE_DEPTH)) : slot_t'(tail_sum);
  assign head_inc  = (head_s == slot_t'(QUEUE_DEPTH - 1)) ? '0 : head_s + slot_t'(1);
  assign base      = addr_t'(lsel_q) * addr_t'(QUEUE_DEPTH);
  assign waddr     = base + addr_t'(tail_slot);
  assign raddr     = base + addr_t'(head_s);

  assign push_op = (op_i == OP_PUSH_WAKE) || (op_i == OP_PUSH_CREATE) ||
                   (op_i == OP_PUSH_PRE) || (op_i == OP_PUSH_QEXP);
  assign push_we = push_op && push_ok;

  assign live_inc = (live_q == LIVE_MAX) ? live_q : live_q + 5'd1;
  assign live_dec = (live_q == 5'd0) ? live_q : live_q - 5'd1;

  always_comb begin
    stat_o            = '0;
    stat_o.cmd        = cmd_q;
    stat_o.id_ok      = id_ok;
    stat_o.create_ok  = create_ok;
    stat_o.io_wait    = id_ok && iow_q[t];
    stat_o.cur_valid  = cur_valid_q;
    stat_o.best_found = best_found;
    stat_o.preempt    = best < prio_t;
    stat_o.qexp       = qexp;
    stat_o.sleep_wake = sleeping_q[t] && wake;
    stat_o.scan_last  = (t == tid_t'(MAX_TASKS - 1));
    stat_o.push_ok    = push_ok;
  end

  always_ff @(posedge clk_i) begin
    if (push_we) qmem[waddr] <= pid_q;
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_POP_RD) rd_q <= qmem[raddr];
  end

  // Payload registers and task tables.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cmd_q  <= command_i;
      id_q   <= task_id_i;
      lvl_q  <= task_level_i;
      iop_q  <= instr_op_i;
      arg_q  <= instr_arg_i;
      plen_q <= program_length_i;
      taddr_q <= (command_i == CMD_DISPATCH || command_i == CMD_EXECUTE) ?
                 cur_task_q : tid_t'(task_id_i);
    end
    unique case (op_i)
      OP_DECODE: begin
        unique case (cmd_q)
          CMD_BEGIN: taddr_q <= '0;
          CMD_IO_DONE: begin
            lsel_q <= prio_t;
            pid_q  <= t;
          end
          CMD_CREATE: begin
            if (create_ok) begin
              prio_q[t] <= lvl_t'(lvl_q);
              pc_q[t]   <= 8'd0;
              lsel_q    <= lvl_t'(lvl_q);
              pid_q     <= t;
            end
          end
          CMD_DISPATCH: begin
            if (!cur_valid_q) begin
              lsel_q <= best;
            end else begin
              lsel_q <= prio_t;
              pid_q  <= t;
            end
          end
          CMD_EXECUTE: begin
            if (cur_valid_q) begin
              pc_q[t] <= pc_new;
              if (iop_q == OPC_SLEEP) sl_q[t] <= arg_q;
              lsel_q <= prio_t;
              pid_q  <= t;
            end
          end
          default: ;
        endcase
      end
      OP_SCAN: begin
        if (sleeping_q[t] && wake) begin
          sl_q[t] <= 16'd0;
          lsel_q  <= prio_t;
          pid_q   <= t;
        end else begin
          if (sleeping_q[t]) sl_q[t] <= sl_t - 16'd1;
          taddr_q <= t + tid_t'(1);
        end
      end
      OP_PUSH_WAKE: taddr_q <= t + tid_t'(1);
      OP_PUSH_PRE:  lsel_q <= best;
      OP_FIN:       taddr_q <= cur_task_q;
      default: ;
    endcase
  end

  // Control state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleeping_q  <= '0;
      iow_q       <= '0;
      fill_q      <= '{default: '0};
      head_q      <= '{default: '0};
      cur_task_q  <= '0;
      cur_valid_q <= 1'b0;
      qleft_q     <= QUANTUM_RESET;
      qlen_q      <= QUANTUM_RESET;
      qfl_q       <= QFIRST_RESET;
      live_q      <= '0;
      status_q    <= ST_OK;
      newly_q     <= 1'b0;
      finv_q      <= 1'b0;
      fint_q      <= '0;
      exec_ok_q   <= 1'b0;
      rv_q        <= 1'b0;
      rtask_q     <= '0;
      rpc_q       <= '0;
      rnew_q      <= 1'b0;
      rfinv_q     <= 1'b0;
      rfint_q     <= '0;
      rlive_q     <= '0;
      rdone_q     <= 1'b0;
      rstat_q     <= ST_OK;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_QUANTUM_LENGTH: qlen_q <= cfg_wdata_i;
          REG_QUANTUM_FIRST:  qfl_q  <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (load_i) begin
        status_q  <= ST_OK;
        newly_q   <= 1'b0;
        finv_q    <= 1'b0;
        fint_q    <= '0;
        exec_ok_q <= 1'b0;
      end
      if (push_op) begin
        if (push_ok) fill_q[lsel_q] <= fill_s + fill_t'(1);
        else status_q <= ST_FULL;
      end
      unique case (op_i)
        OP_DECODE: begin
          unique case (cmd_q)
            CMD_BEGIN: ;
            CMD_IO_DONE: begin
              if (id_ok && iow_q[t]) iow_q[t] <= 1'b0;
              else status_q <= ST_INVALID;
            end
            CMD_CREATE: begin
              if (!create_ok) begin
                status_q <= ST_INVALID;
              end else begin
                sleeping_q[t] <= 1'b0;
                iow_q[t]      <= 1'b0;
                if (!cur_valid_q) begin
                  cur_task_q  <= t;
                  cur_valid_q <= 1'b1;
                  qleft_q     <= qlen_q;
                  newly_q     <= 1'b1;
                  live_q      <= live_inc;
                end
              end
            end
            CMD_DISPATCH: ;
            CMD_EXECUTE: begin
              if (!cur_valid_q) begin
                status_q <= ST_INVALID;
              end else begin
                exec_ok_q <= 1'b1;
                qleft_q   <= qdec;
                if (fin) begin
                  sleeping_q[t] <= 1'b0;
                  iow_q[t]      <= 1'b0;
                  cur_valid_q   <= 1'b0;
                  finv_q        <= 1'b1;
                  fint_q        <= t;
                  live_q        <= live_dec;
                end else if (iop_q == OPC_SLEEP) begin
                  sleeping_q[t] <= 1'b1;
                  cur_valid_q   <= 1'b0;
                end else if (iop_q == OPC_IOWAIT) begin
                  iow_q[t]    <= 1'b1;
                  cur_valid_q <= 1'b0;
                end
              end
            end
            default: status_q <= ST_INVALID;
          endcase
        end
        OP_SCAN: begin
          if (sleeping_q[t] && wake) sleeping_q[t] <= 1'b0;
        end
        OP_PUSH_CREATE: begin
          if (push_ok) live_q <= live_inc;
        end
        OP_PUSH_QEXP: begin
          if (push_ok) cur_valid_q <= 1'b0;
        end
        OP_POP_WR: begin
          cur_task_q     <= rd_q;
          cur_valid_q    <= 1'b1;
          qleft_q        <= qlen_q;
          newly_q        <= 1'b1;
          head_q[lsel_q] <= head_inc;
          fill_q[lsel_q] <= fill_s - fill_t'(1);
        end
        OP_OUT: begin
          rv_q    <= cur_valid_q;
          rtask_q <= cur_valid_q ? 4'(cur_task_q) : 4'd0;
          rpc_q   <= cur_valid_q ? pc_t : 8'd0;
          rnew_q  <= newly_q;
          rfinv_q <= finv_q;
          rfint_q <= 4'(fint_q);
          rlive_q <= live_q;
          rdone_q <= exec_ok_q && (live_q == 5'd0);
          rstat_q <= status_q;
        end
        default: ;
      endcase
    end
  end

  assign running_valid_o   = rv_q;
  assign running_task_o    = rtask_q;
  assign running_pc_o      = rpc_q;
  assign newly_scheduled_o = rnew_q;
  assign finished_valid_o  = rfinv_q;
  assign finished_task_o   = rfint_q;
  assign live_tasks_o      = rlive_q;
  assign all_done_o        = rdone_q;
  assign status_o          = rstat_q;

  // The selected level is meaningful while a push or a pop is under way.
  `SCH_ASSERT(a_fill_bound, clk_i, rst_ni, !push_op || (fill_s <= fill_t'(QUEUE_DEPTH)))
  `SCH_ASSERT_NEXT(a_pop_runs, clk_i, rst_ni, op_i == OP_POP_WR, cur_valid_q)
  `SCH_ASSERT_NEXT(a_fin_idles, clk_i, rst_ni,
    op_i == OP_DECODE && cmd_q == CMD_EXECUTE && cur_valid_q && fin, !cur_valid_q)

endmodule

FILE: hdl/multilevel_priority_task_scheduler_top.sv
// Top level of the multilevel priority task scheduler.
// Depends on mlpts_pkg, mlpts_ctrl and mlpts_dp.
//
//   Channel   Handshake                 Payload
//   command   start_i / busy_o          command_i .. program_length_i
//   result    done_o (one-cycle strobe) running_valid_o .. status_o
//   config    cfg_we_i, cfg_idx_i       cfg_wdata_i
//
// From the command transfer to the result strobe, a command steps through the
// decode, fin and out states when it touches no queue, adds a push state when it
// pushes one entry (a woken I/O waiter, a create while a task runs, a quantum
// expiry), adds the pop read and pop write states for a dispatch that starts the
// head of a level on an idle processor, and for a preempting dispatch pushes the
// preempted task before it pops, if that push succeeds. begin_cycle walks the
// sleep counters one task per cycle and pushes each task that wakes in an extra
// state. busy_o is already low in the strobe cycle, so the next transfer can
// coincide with the strobe. Reset clears all control state and needs no
// clearing pass; the receiver cannot stall, and done_o is high for a single cycle.
module multilevel_priority_task_scheduler_top import mlpts_pkg::*; #(
  parameter int MAX_TASKS   = 16,
  parameter int LEVELS      = 10,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [3:0]  task_id_i,
  input  logic [3:0]  task_level_i,
  input  logic [2:0]  instr_op_i,
  input  logic [15:0] instr_arg_i,
  input  logic [7:0]  program_length_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        done_o,
  output logic        running_valid_o,
  output logic [3:0]  running_task_o,
  output logic [7:0]  running_pc_o,
  output logic        newly_scheduled_o,
  output logic        finished_valid_o,
  output logic [3:0]  finished_task_o,
  output logic [4:0]  live_tasks_o,
  output logic        all_done_o,
  output logic [1:0]  status_o
);

  // The controller sequences micro-operations; the datapath reports back the
  // conditions that steer each branch of the sequence.
  dp_stat_t stat;
  dp_op_e   op;
  logic     load;

  mlpts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .load_o  (load),
    .op_o    (op),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // The datapath holds the task tables, the level queue memory and the
  // result registers that stay stable until the next command's result.
  mlpts_dp #(
    .MAX_TASKS   (MAX_TASKS),
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (load),
    .op_i              (op),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .command_i         (command_i),
    .task_id_i         (task_id_i),
    .task_level_i      (task_level_i),
    .instr_op_i        (instr_op_i),
    .instr_arg_i       (instr_arg_i),
    .program_length_i  (program_length_i),
    .running_valid_o   (running_valid_o),
    .running_task_o    (running_task_o),
    .running_pc_o      (running_pc_o),
    .newly_scheduled_o (newly_scheduled_o),
    .finished_valid_o  (finished_valid_o),
    .finished_task_o   (finished_task_o),
    .live_tasks_o      (live_tasks_o),
    .all_done_o        (all_done_o),
    .status_o          (status_o)
  );

endmodule
